@@ rtl/core/iht_pkg.sv @@
package iht_pkg;

   // Fixed widths of the fragment and result fields.
   localparam int LEN_W        = 16;
   localparam int OFFSET_W     = 13;
   localparam int AGE_W        = 32;
   localparam int STATUS_W     = 3;
   localparam int HOLES_W      = 5;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 32;

   // Default size of the hole table and the fixed IPv4 header size.
   localparam int MAX_HOLES_DEFAULT = 16;
   localparam int HEADER_BYTES      = 20;

   // The hole count is reported saturated to the width of holes_left.
   localparam int HOLES_SAT = 31;

   // Register reset values.
   localparam logic [LEN_W-1:0] MAX_PACKET_LENGTH_RESET = 16'hFFFF;
   localparam logic [AGE_W-1:0] LIFETIME_TICKS_RESET    = 32'd60;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PACKET_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIFETIME_TICKS    = 1'b1;

   // Command codes of an item.
   localparam logic CMD_FRAGMENT = 1'b0;
   localparam logic CMD_TICK     = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_STORED       = 3'd0,
      STATUS_COMPLETE     = 3'd1,
      STATUS_BAD_MULTIPLE = 3'd2,
      STATUS_TOO_BIG      = 3'd3,
      STATUS_MALFORMED    = 3'd4,
      STATUS_OVERFLOW     = 3'd5,
      STATUS_EXPIRED      = 3'd6,
      STATUS_TICK_IDLE    = 3'd7
   } status_type;

endpackage

@@ rtl/core/iht_if.sv @@
interface iht_req_if;
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic [iht_pkg::OFFSET_W-1:0]        fragment_offset;
   logic [iht_pkg::LEN_W-1:0]           total_length;
   logic                                more_frags;

   modport source (output valid, output command, output fragment_offset,
                   output total_length, output more_frags, input ready);
   modport sink   (input valid, input command, input fragment_offset,
                   input total_length, input more_frags, output ready);
endinterface

interface iht_rsp_if;
   logic                                valid;
   logic                                ready;
   iht_pkg::status_type                 status;
   logic [iht_pkg::LEN_W-1:0]           reassembled_length;
   logic [iht_pkg::HOLES_W-1:0]         holes_left;

   modport source (output valid, output status, output reassembled_length,
                   output holes_left, input ready);
   modport sink   (input valid, input status, input reassembled_length,
                   input holes_left, output ready);
endinterface

@@ rtl/core/iht_ram.sv @@
module iht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/iht_slot_find.sv @@
module iht_slot_find #(
   parameter int N = 16
) (
   input  logic [N-1:0]         used,
   output logic                 found,
   output logic [$clog2(N)-1:0] index
);

   localparam int IDX_W = $clog2(N);

   logic [N-1:0] free_vec;
   logic [N-1:0] lowest;

   // The lowest free entry is isolated with one two's complement add.
   assign free_vec = ~used;
   assign lowest   = free_vec & (~free_vec + N'(1));
   assign found    = |free_vec;

   always_comb begin
      index = '0;
      for (int k = 0; k < N; k++) begin
         if (lowest[k]) begin
            index = index | IDX_W'(k);
         end
      end
   end

endmodule

@@ rtl/core/ip_fragment_hole_tracker.sv @@
// A tick passes through the check and report states; a fragment is checked,
// walks every hole table entry in the read state, evaluates each stored hole,
// takes a split state for each hole that is split, then finishes and reports.
// Throughput: one item at a time; the hole walk over the hole RAM, which has one
// read and one write port, sets the rate. A finished result waits in the output register.
// Reset (synchronous, active high) closes the context and restores the registers.
module ip_fragment_hole_tracker #(
   parameter int MAX_HOLES = iht_pkg::MAX_HOLES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   iht_req_if.sink                               req_chan,
   iht_rsp_if.source                             rsp_chan,
   input  logic                                  csr_wr_en,
   input  logic [iht_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [iht_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int IDX_W = $clog2(MAX_HOLES);
   localparam int CNT_W = $clog2(MAX_HOLES + 1);
   localparam int LEN_W = iht_pkg::LEN_W;
   localparam int AGE_W = iht_pkg::AGE_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_HOLES - 1);

   // The controller walks the hole table one entry at a time. Each stored hole is
   // read from the hole RAM, compared against the fragment's byte range, and
   // then cut down in place to its part left of the fragment, or dropped, and, if
   // needed, split: the right part goes to the lowest free slot in a state of its own.
   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_CHECK  = 7'b0000010,
      S_READ   = 7'b0000100,
      S_EVAL   = 7'b0001000,
      S_SPLIT  = 7'b0010000,
      S_FINISH = 7'b0100000,
      S_REPORT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Latched item.
   logic             cmd_ff, cmd_in;
   logic [LEN_W-1:0] first_ff, first_in;
   logic [LEN_W-1:0] tlen_ff, tlen_in;
   logic             more_ff, more_in;
   logic [LEN_W-1:0] last_ff, last_in;
   logic [LEN_W-1:0] hend_ff, hend_in;

   // Configuration registers.
   logic [LEN_W-1:0] max_len_ff, max_len_in;
   logic [AGE_W-1:0] life_ff, life_in;

   // Context state.
   logic                 active_ff, active_in;
   logic [AGE_W-1:0]     age_ff, age_in;
   logic [LEN_W-1:0]     final_ff, final_in;
   logic [MAX_HOLES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;

   // Pending and presented result.
   iht_pkg::status_type          pend_status_ff, pend_status_in;
   logic [LEN_W-1:0]             pend_rlen_ff, pend_rlen_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   iht_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]             rsp_rlen_ff, rsp_rlen_in;
   logic [iht_pkg::HOLES_W-1:0]  rsp_holes_ff, rsp_holes_in;

   // Hole RAM: each entry holds {start, end}.
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [2*LEN_W-1:0]   ram_wdata;
   logic                 ram_re;
   logic [2*LEN_W-1:0]   ram_rdata;

   logic                 slot_found;
   logic [IDX_W-1:0]     slot_idx;

   // Datapath terms of the checks and of the hole compare.
   logic [LEN_W:0]       cur_len;
   logic [LEN_W-1:0]     payload_len;
   logic                 malformed;
   logic                 bad_multiple;
   logic                 too_big;
   logic [AGE_W-1:0]     age_next;
   logic [LEN_W-1:0]     hole_lo;
   logic [LEN_W-1:0]     hole_hi;
   logic                 overlap;
   logic                 keep_left;
   logic                 keep_right;
   logic [iht_pkg::HOLES_W-1:0] holes_sat;

   iht_ram #(
      .WIDTH (2 * LEN_W),
      .DEPTH (MAX_HOLES)
   ) u_hole_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   iht_slot_find #(
      .N (MAX_HOLES)
   ) u_slot_find (
      .used  (valid_ff),
      .found (slot_found),
      .index (slot_idx)
   );

   // The last byte plus one plus the header equals offset plus total length.
   assign cur_len      = {1'b0, first_ff} + {1'b0, tlen_ff};
   assign payload_len  = tlen_ff - LEN_W'(iht_pkg::HEADER_BYTES);
   assign malformed    = (tlen_ff <= LEN_W'(iht_pkg::HEADER_BYTES));
   assign bad_multiple = more_ff && (payload_len[2:0] != 3'd0);
   assign too_big      = (cur_len > {1'b0, max_len_ff});
   assign age_next     = (age_ff == '1) ? age_ff : age_ff + AGE_W'(1);

   assign hole_lo    = ram_rdata[2*LEN_W-1:LEN_W];
   assign hole_hi    = ram_rdata[LEN_W-1:0];
   assign overlap    = !((first_ff > hole_hi) || (last_ff < hole_lo));
   assign keep_left  = (first_ff > hole_lo);
   assign keep_right = (last_ff < hole_hi) && more_ff;

   always_comb begin
      if (!active_ff) begin
         holes_sat = '0;
      end else if (32'(count_ff) > 32'(iht_pkg::HOLES_SAT)) begin
         holes_sat = iht_pkg::HOLES_W'(iht_pkg::HOLES_SAT);
      end else begin
         holes_sat = iht_pkg::HOLES_W'(count_ff);
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      first_in       = first_ff;
      tlen_in        = tlen_ff;
      more_in        = more_ff;
      last_in        = last_ff;
      hend_in        = hend_ff;
      max_len_in     = max_len_ff;
      life_in        = life_ff;
      active_in      = active_ff;
      age_in         = age_ff;
      final_in       = final_ff;
      valid_in       = valid_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      pend_status_in = pend_status_ff;
      pend_rlen_in   = pend_rlen_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_rlen_in    = rsp_rlen_ff;
      rsp_holes_in   = rsp_holes_ff;
      ram_we         = 1'b0;
      ram_waddr      = idx_ff;
      ram_wdata      = {hole_lo, first_ff - LEN_W'(1)};
      ram_re         = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // The user must write configuration only while the block is idle; the block itself does not enforce it.
      if (csr_wr_en) begin
         unique case (csr_index)
            iht_pkg::CSR_MAX_PACKET_LENGTH: max_len_in = csr_wdata[LEN_W-1:0];
            iht_pkg::CSR_LIFETIME_TICKS:    life_in    = csr_wdata[AGE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in   = req_chan.command;
               first_in = {req_chan.fragment_offset, 3'b000};
               tlen_in  = req_chan.total_length;
               more_in  = req_chan.more_frags;
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            pend_rlen_in = '0;
            state_in     = S_REPORT;
            if (cmd_ff == iht_pkg::CMD_TICK) begin
               pend_status_in = iht_pkg::STATUS_TICK_IDLE;
               if (active_ff) begin
                  age_in = age_next;
                  if (age_next >= life_ff) begin
                     active_in      = 1'b0;
                     age_in         = '0;
                     final_in       = '0;
                     valid_in       = '0;
                     count_in       = '0;
                     pend_status_in = iht_pkg::STATUS_EXPIRED;
                  end
               end
            end else if (malformed || bad_multiple || too_big) begin
               // A rejected fragment drops the context, also a fresh one.
               active_in = 1'b0;
               age_in    = '0;
               final_in  = '0;
               valid_in  = '0;
               count_in  = '0;
               if (malformed) begin
                  pend_status_in = iht_pkg::STATUS_MALFORMED;
               end else if (bad_multiple) begin
                  pend_status_in = iht_pkg::STATUS_BAD_MULTIPLE;
               end else begin
                  pend_status_in = iht_pkg::STATUS_TOO_BIG;
               end
            end else begin
               last_in  = LEN_W'(cur_len - (LEN_W + 1)'(iht_pkg::HEADER_BYTES + 1));
               idx_in   = '0;
               state_in = S_READ;
               if (!active_ff) begin
                  // Open a context with one hole from byte 0 to the maximum packet length.
                  active_in = 1'b1;
                  age_in    = '0;
                  final_in  = '0;
                  valid_in  = MAX_HOLES'(1);
                  count_in  = CNT_W'(1);
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = {{LEN_W{1'b0}}, max_len_ff};
               end
               if (!more_ff) begin
                  final_in = cur_len[LEN_W-1:0];
               end
            end
         end

         S_READ: begin
            if (valid_ff[idx_ff]) begin
               ram_re   = 1'b1;
               state_in = S_EVAL;
            end else if (idx_ff == LAST_IDX) begin
               state_in = S_FINISH;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         S_EVAL: begin
            hend_in = hole_hi;
            if (overlap) begin
               if (keep_left) begin
                  ram_we = 1'b1;
               end else begin
                  valid_in[idx_ff] = 1'b0;
                  count_in         = count_ff - CNT_W'(1);
               end
            end
            if (overlap && keep_right) begin
               state_in = S_SPLIT;
            end else if (idx_ff == LAST_IDX) begin
               state_in = S_FINISH;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_READ;
            end
         end

         S_SPLIT: begin
            if (!slot_found) begin
               active_in      = 1'b0;
               age_in         = '0;
               final_in       = '0;
               valid_in       = '0;
               count_in       = '0;
               pend_status_in = iht_pkg::STATUS_OVERFLOW;
               state_in       = S_REPORT;
            end else begin
               ram_we             = 1'b1;
               ram_waddr          = slot_idx;
               ram_wdata          = {last_ff + LEN_W'(1), hend_ff};
               valid_in[slot_idx] = 1'b1;
               count_in           = count_ff + CNT_W'(1);
               if (idx_ff == LAST_IDX) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_READ;
               end
            end
         end

         S_FINISH: begin
            state_in = S_REPORT;
            if (count_ff == '0) begin
               pend_status_in = iht_pkg::STATUS_COMPLETE;
               pend_rlen_in   = final_ff;
               active_in      = 1'b0;
               age_in         = '0;
               final_in       = '0;
               valid_in       = '0;
            end else begin
               pend_status_in = iht_pkg::STATUS_STORED;
            end
         end

         S_REPORT: begin
            // Wait here only while the previous result is still not taken.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_rlen_in   = pend_rlen_ff;
               rsp_holes_in  = holes_sat;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_len_ff   <= iht_pkg::MAX_PACKET_LENGTH_RESET;
         life_ff      <= iht_pkg::LIFETIME_TICKS_RESET;
         active_ff    <= 1'b0;
         age_ff       <= '0;
         final_ff     <= '0;
         valid_ff     <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_len_ff   <= max_len_in;
         life_ff      <= life_in;
         active_ff    <= active_in;
         age_ff       <= age_in;
         final_ff     <= final_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      first_ff       <= first_in;
      tlen_ff        <= tlen_in;
      more_ff        <= more_in;
      last_ff        <= last_in;
      hend_ff        <= hend_in;
      pend_status_ff <= pend_status_in;
      pend_rlen_ff   <= pend_rlen_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_rlen_ff    <= rsp_rlen_in;
      rsp_holes_ff   <= rsp_holes_in;
   end

   // An item is taken only in the idle state.
   assign req_chan.ready              = (state_ff == S_IDLE);
   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.status             = rsp_status_ff;
   assign rsp_chan.reassembled_length = rsp_rlen_ff;
   assign rsp_chan.holes_left         = rsp_holes_ff;

endmodule

@@ rtl/core/iht_checker.sv @@
module iht_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [iht_pkg::STATUS_W-1:0]  rsp_status,
   input logic [iht_pkg::LEN_W-1:0]     rsp_rlen,
   input logic [iht_pkg::HOLES_W-1:0]   rsp_holes
);

   // A stalled result keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_rlen) && $stable(rsp_holes))
      else $error("result changed while stalled");

   // Only one item is worked on at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while busy");

   // A length is reported only for a completed packet.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != iht_pkg::STATUS_COMPLETE) |-> rsp_rlen == '0)
      else $error("length on an incomplete packet");

   // A closed context leaves no holes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != iht_pkg::STATUS_STORED)
         && (rsp_status != iht_pkg::STATUS_TICK_IDLE) |-> rsp_holes == '0)
      else $error("holes left after the context closed");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result present after reset");

endmodule

bind ip_fragment_hole_tracker iht_checker u_iht_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_rlen   (rsp_chan.reassembled_length),
   .rsp_holes  (rsp_chan.holes_left)
);
